@@ rtl/core/mnfd_pkg.sv @@
package mnfd_pkg;

  localparam logic [3:0] SKIP_RESET = 4'd6;
  localparam logic [2:0] GROUP_LEN  = 3'd5;
  localparam int         PAIRS      = 4;

  typedef struct packed {
    logic [3:0] skip_left;
    logic [4:0] group_bits;
    logic [2:0] group_fill;
    logic [3:0] high_nibble;
    logic       have_high;
  } dec_state_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } result_t;

  function automatic dec_state_t frame_restart(input logic [3:0] skip);
    dec_state_t s;
    s           = '0;
    s.skip_left = skip;
    return s;
  endfunction

endpackage

@@ rtl/core/mnfd_core.sv @@
module mnfd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          skip_count,
  input  logic                restart,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                frame_last,
  output mnfd_pkg::result_t   res
);

  mnfd_pkg::dec_state_t st_r;
  mnfd_pkg::dec_state_t st_nxt;

  always_comb begin
    logic [4:0] gb;
    logic [2:0] gf;
    logic [3:0] hn;
    logic       hh;
    logic       b;
    gb       = st_r.group_bits;
    gf       = st_r.group_fill;
    hn       = st_r.high_nibble;
    hh       = st_r.have_high;
    b        = 1'b0;
    st_nxt   = st_r;
    res      = '0;
    if (st_r.skip_left != 4'd0) begin
      st_nxt.skip_left = st_r.skip_left - 4'd1;
    end else begin
      for (int k = 0; k < mnfd_pkg::PAIRS; k++) begin
        b  = data_byte[3'(7 - 2 * k)];
        gb = gb | (5'(b) << gf);
        gf = gf + 3'd1;
        if (gf == mnfd_pkg::GROUP_LEN) begin
          if (hh) begin
            res.vld  = 1'b1;
            res.data = {hn, gb[3:0]};
            hh       = 1'b0;
            hn       = 4'd0;
          end else begin
            hn = gb[3:0];
            hh = 1'b1;
          end
          gb = 5'd0;
          gf = 3'd0;
        end
      end
      st_nxt.group_bits  = gb;
      st_nxt.group_fill  = gf;
      st_nxt.high_nibble = hn;
      st_nxt.have_high   = hh;
    end
    if (frame_last) begin
      st_nxt = mnfd_pkg::frame_restart(skip_count);
    end
    if (!fire) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mnfd_pkg::frame_restart(mnfd_pkg::SKIP_RESET);
    end else if (restart) begin
      st_r <= mnfd_pkg::frame_restart(skip_count);
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

endmodule

@@ rtl/core/mnfd_outbuf.sv @@
module mnfd_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  mnfd_pkg::result_t push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte
);

  logic       out_vld_r;
  logic       out_vld_nxt;
  logic [7:0] out_data_r;
  logic [7:0] out_data_nxt;
  logic       skid_vld_r;
  logic       skid_vld_nxt;
  logic [7:0] skid_data_r;
  logic [7:0] skid_data_nxt;

  assign room      = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_byte  = out_data_r;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_data_nxt  = out_data_r;
    skid_vld_nxt  = skid_vld_r;
    skid_data_nxt = skid_data_r;
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = skid_data_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt  = push.vld;
        out_data_nxt = push.data;
      end
    end else if (push.vld) begin
      skid_vld_nxt  = 1'b1;
      skid_data_nxt = push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty output register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !skid_vld_r)
    else $error("result pushed into full buffer");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready && push.vld) |=> (skid_vld_r && skid_data_r == $past(push.data)))
    else $error("stalled result not captured in skid entry");

endmodule

@@ rtl/core/manchester_nibble_frame_decoder.sv @@
// Manchester frame decoder: takes one raw frame byte per cycle while the
// output buffer has room, skips the first cfg_skip_count bytes of each frame,
// keeps bits 7/5/3/1 of later bytes, packs them in five-bit groups (four data
// bits, first bit as LSB, plus a dropped stop bit) and emits one decoded byte
// per two nibbles, first nibble high. out_valid follows the input accept
// through the input register, then the result register. A two-entry output
// buffer keeps input flowing while a result waits. in_frame_last clears
// partial state after its byte; a write to cfg_skip_count also starts a frame.
module manchester_nibble_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_skip_count,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);

  logic [3:0]        skip_count_r;
  logic              in_vld_r;
  logic [7:0]        in_data_r;
  logic              in_last_r;
  logic              room;
  logic              fire;
  mnfd_pkg::result_t res;

  assign fire     = in_vld_r && room;
  assign in_ready = !in_vld_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= mnfd_pkg::SKIP_RESET;
      in_vld_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        skip_count_r <= cfg_skip_count;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
    end
    if (in_ready && in_valid) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_frame_last;
    end
  end

  mnfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .skip_count (cfg_we ? cfg_skip_count : skip_count_r),
    .restart    (cfg_we),
    .fire       (fire),
    .data_byte  (in_data_r),
    .frame_last (in_last_r),
    .res        (res)
  );

  mnfd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
  );

endmodule
